// ===== design/fct_pkg.sv =====
package fct_pkg;

  localparam int MAX_PLANES      = 8;
  localparam int REG_COUNT       = 6;
  localparam int CFG_IDX_BITS    = 3;
  localparam int PLANE_BITS      = 64;
  localparam int NORM_BITS       = 12;
  localparam int OFF_BITS        = 28;
  localparam int OFF_LSB         = 36;
  localparam int FRAC_SHIFT      = 10;
  localparam int CORNERS         = 8;
  localparam int PLANE_COUNT_DEF = 6;
  localparam int COORD_BITS_DEF  = 24;

  localparam logic [1:0] FUNC_POINT  = 2'd0;
  localparam logic [1:0] FUNC_SPHERE = 2'd1;
  localparam logic [1:0] FUNC_BOX    = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  localparam logic [1:0] VERDICT_OUTSIDE = 2'd0;
  localparam logic [1:0] VERDICT_CUT     = 2'd1;
  localparam logic [1:0] VERDICT_INSIDE  = 2'd2;
  localparam logic [1:0] VERDICT_RSVD    = 2'd3;

  typedef struct packed {
    logic pos;
    logic sph_out;
    logic sph_cut;
    logic box_out;
    logic box_in;
  } fct_plane_flags_t;

  typedef struct packed {
    logic [MAX_PLANES-1:0] pos;
    logic [MAX_PLANES-1:0] sph_out;
    logic [MAX_PLANES-1:0] sph_cut;
    logic [MAX_PLANES-1:0] box_out;
    logic [MAX_PLANES-1:0] box_in;
  } fct_flags_t;

  function automatic int fct_dist_bits(input int cb);
    return ((cb + NORM_BITS > OFF_BITS + FRAC_SHIFT) ? cb + NORM_BITS
                                                     : OFF_BITS + FRAC_SHIFT) + 2;
  endfunction

endpackage

// ===== design/fct_plane_regs.sv =====
module fct_plane_regs import fct_pkg::*; #(
  parameter int PLANE_COUNT = PLANE_COUNT_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  input  logic [CFG_IDX_BITS-1:0]                cfg_index_i,
  input  logic [PLANE_BITS-1:0]                  cfg_data_i,
  output logic [PLANE_COUNT-1:0][PLANE_BITS-1:0] plane_o
);

  for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_plane
    if (k < REG_COUNT) begin : g_reg
      logic [PLANE_BITS-1:0] plane_q;

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          plane_q <= '0;
        end else if (cfg_valid_i && (cfg_index_i == CFG_IDX_BITS'(k))) begin
          plane_q <= cfg_data_i;
        end
      end

      assign plane_o[k] = plane_q;
    end else begin : g_zero
      assign plane_o[k] = '0;
    end
  end

endmodule

// ===== design/fct_plane_unit.sv =====
module fct_plane_unit import fct_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                           clk_i,
  input  logic [PLANE_BITS-1:0]                          plane_i,
  input  logic signed [COORD_BITS-1:0]                   x_low_i,
  input  logic signed [COORD_BITS-1:0]                   y_low_i,
  input  logic signed [COORD_BITS-1:0]                   z_low_i,
  input  logic signed [COORD_BITS-1:0]                   x_high_i,
  input  logic signed [COORD_BITS-1:0]                   y_high_i,
  input  logic signed [COORD_BITS-1:0]                   z_high_i,
  input  logic signed [fct_dist_bits(COORD_BITS)-1:0]    rad_i,
  output fct_plane_flags_t                               flags_o
);

  localparam int ProdBits = COORD_BITS + NORM_BITS;
  localparam int DistBits = fct_dist_bits(COORD_BITS);

  logic signed [NORM_BITS-1:0] nx, ny, nz;
  logic signed [OFF_BITS+FRAC_SHIFT-1:0] off_s;

  logic signed [ProdBits-1:0] pxl_q, pxh_q, pyl_q, pyh_q, pzl_q, pzh_q;
  logic signed [DistBits-1:0] csum [CORNERS];
  logic [CORNERS-1:0]         neg_d, neg_q;
  logic signed [DistBits-1:0] d0_q;
  logic signed [DistBits-1:0] nrad;
  fct_plane_flags_t           flags_d, flags_q;

  assign nx    = $signed(plane_i[NORM_BITS-1:0]);
  assign ny    = $signed(plane_i[2*NORM_BITS-1:NORM_BITS]);
  assign nz    = $signed(plane_i[3*NORM_BITS-1:2*NORM_BITS]);
  assign off_s = $signed({plane_i[OFF_LSB+OFF_BITS-1:OFF_LSB], {FRAC_SHIFT{1'b0}}});

  always_ff @(posedge clk_i) begin
    pxl_q <= nx * x_low_i;
    pxh_q <= nx * x_high_i;
    pyl_q <= ny * y_low_i;
    pyh_q <= ny * y_high_i;
    pzl_q <= nz * z_low_i;
    pzh_q <= nz * z_high_i;
  end

  always_comb begin
    for (int c = 0; c < CORNERS; c++) begin
      csum[c] = DistBits'(((c & 1) != 0) ? pxh_q : pxl_q)
              + DistBits'(((c & 2) != 0) ? pyh_q : pyl_q)
              + DistBits'(((c & 4) != 0) ? pzh_q : pzl_q)
              + DistBits'(off_s);
      neg_d[c] = csum[c][DistBits-1];
    end
  end

  always_ff @(posedge clk_i) begin
    d0_q  <= csum[0];
    neg_q <= neg_d;
  end

  assign nrad = -rad_i;

  always_comb begin
    flags_d.pos     = !d0_q[DistBits-1] && (d0_q != '0);
    flags_d.sph_out = d0_q < nrad;
    flags_d.sph_cut = (d0_q < rad_i) && (d0_q > nrad);
    flags_d.box_out = &neg_q;
    flags_d.box_in  = ~|neg_q;
  end

  always_ff @(posedge clk_i) begin
    flags_q <= flags_d;
  end

  assign flags_o = flags_q;

endmodule

// ===== design/fct_verdict.sv =====
module fct_verdict import fct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [1:0] func_i,
  input  fct_flags_t flags_i,
  output logic       done_o,
  output logic [1:0] verdict_o
);

  logic       done_q;
  logic [1:0] verdict_d, verdict_q;

  always_comb begin
    case (func_i)
      FUNC_POINT: begin
        verdict_d = (&flags_i.pos) ? VERDICT_INSIDE : VERDICT_OUTSIDE;
      end
      FUNC_SPHERE: begin
        if (|flags_i.sph_out) begin
          verdict_d = VERDICT_OUTSIDE;
        end else if (|flags_i.sph_cut) begin
          verdict_d = VERDICT_CUT;
        end else begin
          verdict_d = VERDICT_INSIDE;
        end
      end
      FUNC_BOX: begin
        if (|flags_i.box_out) begin
          verdict_d = VERDICT_OUTSIDE;
        end else if (&flags_i.box_in) begin
          verdict_d = VERDICT_INSIDE;
        end else begin
          verdict_d = VERDICT_CUT;
        end
      end
      default: begin
        verdict_d = VERDICT_OUTSIDE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
  end

  assign done_o    = done_q;
  assign verdict_o = verdict_q;

endmodule

// ===== design/frustum_cull_test.sv =====
// Point, sphere and box test against up to six configurable planes.
// Input: a word is taken at each rising edge with start_i high and busy_o low.
// busy_o stays low, so a new word may be given in every cycle.
// Output: done_o is high for one cycle with verdict_o (0 outside,
// 1 intersecting, 2 inside); the receiver must take it in that cycle.
// The result is set by the multiply, corner sum, compare and reduce register
// stages, in that order.
// Throughput: one word per cycle; each plane has its own six multipliers
// and eight corner adders.
// Configuration: plane k is written through cfg_valid_i / cfg_index_i /
// cfg_data_i; cfg_ready_o is always high; indexes of six or more are
// dropped. Write only while no test is in flight.
// Reset: planes clear to zero and the pipeline empties; no result follows.
module frustum_cull_test import fct_pkg::*; #(
  parameter int PLANE_COUNT = PLANE_COUNT_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   func_i,
  input  logic signed [COORD_BITS-1:0] x_low_i,
  input  logic signed [COORD_BITS-1:0] y_low_i,
  input  logic signed [COORD_BITS-1:0] z_low_i,
  input  logic signed [COORD_BITS-1:0] x_high_i,
  input  logic signed [COORD_BITS-1:0] y_high_i,
  input  logic signed [COORD_BITS-1:0] z_high_i,
  input  logic [COORD_BITS-2:0]        radius_i,
  output logic                         done_o,
  output logic [1:0]                   verdict_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [PLANE_BITS-1:0]        cfg_data_i
);

  localparam int DistBits = fct_dist_bits(COORD_BITS);
  localparam int RadPad   = DistBits - (COORD_BITS - 1) - FRAC_SHIFT;

  logic [PLANE_COUNT-1:0][PLANE_BITS-1:0] plane;
  fct_plane_flags_t                       pflags [PLANE_COUNT];
  fct_flags_t                             flags;

  logic                       accept;
  logic [2:0]                 valid_q;
  logic [1:0]                 func0_q, func1_q, func2_q;
  logic signed [DistBits-1:0] rad0_d, rad0_q, rad1_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  fct_plane_regs #(
    .PLANE_COUNT (PLANE_COUNT)
  ) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .plane_o     (plane)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], accept};
    end
  end

  assign rad0_d = $signed({{RadPad{1'b0}}, radius_i, {FRAC_SHIFT{1'b0}}});

  always_ff @(posedge clk_i) begin
    func0_q <= func_i;
    func1_q <= func0_q;
    func2_q <= func1_q;
    rad0_q  <= rad0_d;
    rad1_q  <= rad0_q;
  end

  for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_unit
    fct_plane_unit #(
      .COORD_BITS (COORD_BITS)
    ) u_unit (
      .clk_i    (clk_i),
      .plane_i  (plane[k]),
      .x_low_i  (x_low_i),
      .y_low_i  (y_low_i),
      .z_low_i  (z_low_i),
      .x_high_i (x_high_i),
      .y_high_i (y_high_i),
      .z_high_i (z_high_i),
      .rad_i    (rad1_q),
      .flags_o  (pflags[k])
    );
  end

  for (genvar k = 0; k < MAX_PLANES; k++) begin : g_flags
    if (k < PLANE_COUNT) begin : g_live
      assign flags.pos[k]     = pflags[k].pos;
      assign flags.sph_out[k] = pflags[k].sph_out;
      assign flags.sph_cut[k] = pflags[k].sph_cut;
      assign flags.box_out[k] = pflags[k].box_out;
      assign flags.box_in[k]  = pflags[k].box_in;
    end else begin : g_idle
      assign flags.pos[k]     = 1'b1;
      assign flags.sph_out[k] = 1'b0;
      assign flags.sph_cut[k] = 1'b0;
      assign flags.box_out[k] = 1'b0;
      assign flags.box_in[k]  = 1'b1;
    end
  end

  fct_verdict u_verdict (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (valid_q[2]),
    .func_i    (func2_q),
    .flags_i   (flags),
    .done_o    (done_o),
    .verdict_o (verdict_o)
  );

  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 4))
    else $error("result without an accepted word");

  a_point_no_cut: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(func_i == FUNC_POINT, 4)) |-> (verdict_o != VERDICT_CUT))
    else $error("point test gave intersecting");

  a_unknown_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(func_i == FUNC_NONE, 4)) |-> (verdict_o == VERDICT_OUTSIDE))
    else $error("unknown test kind not outside");

  a_zero_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past((func_i == FUNC_SPHERE) && (radius_i == '0), 4))
      |-> (verdict_o != VERDICT_CUT))
    else $error("zero radius sphere gave intersecting");

  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (verdict_o != VERDICT_RSVD))
    else $error("reserved verdict code");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import fct_pkg::*;

  localparam int CW           = COORD_BITS_DEF;
  localparam int RW           = COORD_BITS_DEF - 1;
  localparam int PLANES       = PLANE_COUNT_DEF;
  localparam int UNIT         = 256;
  localparam int DRAIN_CYCLES = 8;
  localparam int QUIET_LIMIT  = 1000;
  localparam int SHOWN_MAX    = 50;
  localparam int PHASE_WORDS  = 200;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    PLANE_RIGHT, PLANE_LEFT, PLANE_BOTTOM, PLANE_TOP,
    PLANE_FAR, PLANE_NEAR, PLANE_SPARE6, PLANE_SPARE7
  } plane_index_e;

  typedef struct packed {
    logic [1:0]           func;
    logic signed [CW-1:0] x_low;
    logic signed [CW-1:0] y_low;
    logic signed [CW-1:0] z_low;
    logic signed [CW-1:0] x_high;
    logic signed [CW-1:0] y_high;
    logic signed [CW-1:0] z_high;
    logic [RW-1:0]        radius;
  } cull_query_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic [1:0]              func_i;
  logic signed [CW-1:0]    x_low_i;
  logic signed [CW-1:0]    y_low_i;
  logic signed [CW-1:0]    z_low_i;
  logic signed [CW-1:0]    x_high_i;
  logic signed [CW-1:0]    y_high_i;
  logic signed [CW-1:0]    z_high_i;
  logic [RW-1:0]           radius_i;
  logic                    done_o;
  logic [1:0]              verdict_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  logic [PLANE_BITS-1:0]   cfg_data_i;

  logic [PLANE_BITS-1:0] plane_set [MAX_PLANES];
  logic [1:0]            verdicts_due [$];
  int                    errors = 0;
  int                    quiet = 0;
  bit                    no_gaps = 1'b0;

  frustum_cull_test uut (.*);

  always #5 clk_i = ~clk_i;

  task automatic flag_mismatch(input string msg);
    errors++;
    if (errors <= SHOWN_MAX) $display("%0t mismatch: %s", $time, msg);
  endtask

  function automatic longint plane_distance(int k, longint x, longint y, longint z);
    logic [PLANE_BITS-1:0] p;
    longint nx, ny, nz, off;
    p = plane_set[k];
    nx = longint'($signed(p[NORM_BITS-1:0]));
    ny = longint'($signed(p[2*NORM_BITS-1:NORM_BITS]));
    nz = longint'($signed(p[3*NORM_BITS-1:2*NORM_BITS]));
    off = longint'($signed(p[PLANE_BITS-1:OFF_LSB]));
    return nx * x + ny * y + nz * z + (off <<< FRAC_SHIFT);
  endfunction

  function automatic logic [1:0] classify_volume(cull_query_t q);
    longint lo [3];
    longint hi [3];
    longint reach, d, cx, cy, cz;
    bit all_pos, out_any, cut_any;
    int neg, planes_in;
    logic [1:0] verdict;
    lo[0] = longint'($signed(q.x_low));
    lo[1] = longint'($signed(q.y_low));
    lo[2] = longint'($signed(q.z_low));
    hi[0] = longint'($signed(q.x_high));
    hi[1] = longint'($signed(q.y_high));
    hi[2] = longint'($signed(q.z_high));
    reach = longint'(q.radius) <<< FRAC_SHIFT;
    all_pos = 1'b1;
    out_any = 1'b0;
    cut_any = 1'b0;
    planes_in = 0;
    verdict = VERDICT_OUTSIDE;
    case (q.func)
      FUNC_POINT: begin
        for (int k = 0; k < PLANES; k++)
          if (plane_distance(k, lo[0], lo[1], lo[2]) <= 0) all_pos = 1'b0;
        verdict = all_pos ? VERDICT_INSIDE : VERDICT_OUTSIDE;
      end
      FUNC_SPHERE: begin
        for (int k = 0; k < PLANES; k++) begin
          d = plane_distance(k, lo[0], lo[1], lo[2]);
          if (d < -reach) out_any = 1'b1;
          if ((d < 0 ? -d : d) < reach) cut_any = 1'b1;
        end
        verdict = out_any ? VERDICT_OUTSIDE : (cut_any ? VERDICT_CUT : VERDICT_INSIDE);
      end
      FUNC_BOX: begin
        for (int k = 0; k < PLANES; k++) begin
          neg = 0;
          for (int c = 0; c < CORNERS; c++) begin
            cx = c[0] ? hi[0] : lo[0];
            cy = c[1] ? hi[1] : lo[1];
            cz = c[2] ? hi[2] : lo[2];
            if (plane_distance(k, cx, cy, cz) < 0) neg++;
          end
          if (neg == CORNERS) out_any = 1'b1;
          if (neg == 0) planes_in++;
        end
        if (out_any) verdict = VERDICT_OUTSIDE;
        else if (planes_in == PLANES) verdict = VERDICT_INSIDE;
        else verdict = VERDICT_CUT;
      end
      default: verdict = VERDICT_OUTSIDE;
    endcase
    return verdict;
  endfunction

  always @(posedge clk_i) begin
    cull_query_t q;
    logic [1:0] want;
    if (done_o) begin
      if (verdicts_due.size() == 0) begin
        flag_mismatch($sformatf("verdict %0d with none outstanding", verdict_o));
      end else begin
        want = verdicts_due.pop_front();
        if (verdict_o !== want)
          flag_mismatch($sformatf("verdict %0d, want %0d", verdict_o, want));
      end
    end
    if (rst_ni && cfg_valid_i && cfg_ready_o && cfg_index_i < REG_COUNT)
      plane_set[cfg_index_i] = cfg_data_i;
    if (rst_ni && start_i && !busy_o) begin
      q.func = func_i;
      q.x_low = x_low_i;
      q.y_low = y_low_i;
      q.z_low = z_low_i;
      q.x_high = x_high_i;
      q.y_high = y_high_i;
      q.z_high = z_high_i;
      q.radius = radius_i;
      verdicts_due.push_back(classify_volume(q));
    end
    if (done_o || (start_i && !busy_o) || (cfg_valid_i && cfg_ready_o)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_query(input cull_query_t q);
    @(negedge clk_i);
    while (!no_gaps && $urandom_range(99) < 32) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    func_i <= q.func;
    x_low_i <= q.x_low;
    y_low_i <= q.y_low;
    z_low_i <= q.z_low;
    x_high_i <= q.x_high;
    y_high_i <= q.y_high;
    z_high_i <= q.z_high;
    radius_i <= q.radius;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic write_plane(input plane_index_e idx, input logic [PLANE_BITS-1:0] value);
    @(negedge clk_i);
    while (!no_gaps && $urandom_range(99) < 32) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [PLANE_BITS-1:0] pack_plane(int nx, int ny, int nz, int off);
    return {off[OFF_BITS-1:0], nz[NORM_BITS-1:0], ny[NORM_BITS-1:0], nx[NORM_BITS-1:0]};
  endfunction

  function automatic cull_query_t pack_query(logic [1:0] func, int xl, int yl, int zl,
                                             int xh, int yh, int zh, int r);
    cull_query_t q;
    q.func = func;
    q.x_low = CW'(xl);
    q.y_low = CW'(yl);
    q.z_low = CW'(zl);
    q.x_high = CW'(xh);
    q.y_high = CW'(yh);
    q.z_high = CW'(zh);
    q.radius = RW'(r);
    return q;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord(int span);
    if ($urandom_range(99) < 15) return CW'($urandom);
    return CW'(int'($urandom_range(2 * span)) - span);
  endfunction

  function automatic cull_query_t random_query(int span);
    cull_query_t q;
    int pick;
    q.func = ($urandom_range(99) < 5) ? FUNC_NONE : 2'($urandom_range(2));
    q.x_low = rand_coord(span);
    q.y_low = rand_coord(span);
    q.z_low = rand_coord(span);
    if (q.func == FUNC_BOX && $urandom_range(99) < 85) begin
      q.x_high = CW'(int'($signed(q.x_low)) + int'($urandom_range(span)));
      q.y_high = CW'(int'($signed(q.y_low)) + int'($urandom_range(span)));
      q.z_high = CW'(int'($signed(q.z_low)) + int'($urandom_range(span)));
    end else begin
      q.x_high = rand_coord(span);
      q.y_high = rand_coord(span);
      q.z_high = rand_coord(span);
    end
    pick = $urandom_range(99);
    if (pick < 10) q.radius = '0;
    else if (pick < 25) q.radius = RW'($urandom);
    else q.radius = RW'($urandom_range(span));
    return q;
  endfunction

  task automatic load_cube(input int half);
    write_plane(PLANE_RIGHT,  pack_plane(-1024, 0, 0, half));
    write_plane(PLANE_LEFT,   pack_plane(1024, 0, 0, half));
    write_plane(PLANE_BOTTOM, pack_plane(0, 1024, 0, half));
    write_plane(PLANE_TOP,    pack_plane(0, -1024, 0, half));
    write_plane(PLANE_FAR,    pack_plane(0, 0, -1024, half));
    write_plane(PLANE_NEAR,   pack_plane(0, 0, 1024, half));
  endtask

  task automatic load_skewed_planes(input bit full_width);
    for (int k = PLANE_RIGHT; k <= PLANE_NEAR; k++) begin
      if (full_width)
        write_plane(plane_index_e'(k), {$urandom, $urandom});
      else
        write_plane(plane_index_e'(k),
                    pack_plane(int'($urandom_range(4095)) - 2048,
                               int'($urandom_range(4095)) - 2048,
                               int'($urandom_range(4095)) - 2048,
                               int'($urandom_range(1 << 21)) - (1 << 20)));
    end
  endtask

  task automatic load_all(input logic [PLANE_BITS-1:0] value);
    for (int k = PLANE_RIGHT; k <= PLANE_NEAR; k++) write_plane(plane_index_e'(k), value);
  endtask

  task automatic test_zero_planes();
    send_query(pack_query(FUNC_POINT, 0, 0, 0, 0, 0, 0, 0));
    send_query(pack_query(FUNC_SPHERE, 0, 0, 0, 0, 0, 0, 0));
    send_query(pack_query(FUNC_SPHERE, 0, 0, 0, 0, 0, 0, 8388607));
    send_query(pack_query(FUNC_NONE, -1, -1, -1, -1, -1, -1, 8388607));
    settle();
  endtask

  task automatic test_plane_registers();
    load_all('1);
    send_query(pack_query(FUNC_POINT, UNIT, UNIT, UNIT, 0, 0, 0, 0));
    send_query(pack_query(FUNC_BOX, -UNIT, -UNIT, -UNIT, UNIT, UNIT, UNIT, 0));
    settle();
    load_all(64'h8000_0008_0080_0800);
    send_query(pack_query(FUNC_SPHERE, 8388607, 8388607, 8388607, 0, 0, 0, 4096));
    send_query(pack_query(FUNC_BOX, -8388608, -8388608, -8388608, 0, 0, 0, 0));
    settle();
    load_all(64'h7FFF_FFF7_FF7F_F7FF);
    send_query(pack_query(FUNC_POINT, -8388608, -8388608, -8388608, 0, 0, 0, 0));
    send_query(pack_query(FUNC_SPHERE, 0, 0, 0, 0, 0, 0, 8388607));
    settle();
    // spare indexes must leave the planes alone
    write_plane(PLANE_SPARE6, {$urandom, $urandom});
    write_plane(PLANE_SPARE7, '0);
    send_query(pack_query(FUNC_POINT, 0, 0, 0, 0, 0, 0, 0));
    settle();
  endtask

  task automatic test_directed_cube();
    int a;
    a = 100 * UNIT;
    load_cube(a);
    send_query(pack_query(FUNC_POINT, 0, 0, 0, 0, 0, 0, 0));
    send_query(pack_query(FUNC_POINT, a, 0, 0, 0, 0, 0, 0));
    send_query(pack_query(FUNC_POINT, -8388608, 8388607, -8388608, 0, 0, 0, 0));
    send_query(pack_query(FUNC_SPHERE, 0, 0, 0, 0, 0, 0, 50 * UNIT));
    send_query(pack_query(FUNC_SPHERE, 0, 0, 0, 0, 0, 0, a));
    send_query(pack_query(FUNC_SPHERE, 90 * UNIT, 0, 0, 0, 0, 0, 20 * UNIT));
    send_query(pack_query(FUNC_SPHERE, 130 * UNIT, 0, 0, 0, 0, 0, 20 * UNIT));
    send_query(pack_query(FUNC_SPHERE, a, 0, 0, 0, 0, 0, 0));
    send_query(pack_query(FUNC_SPHERE, 0, 0, 0, 0, 0, 0, 8388607));
    send_query(pack_query(FUNC_BOX, -50 * UNIT, -50 * UNIT, -50 * UNIT,
                          50 * UNIT, 50 * UNIT, 50 * UNIT, 0));
    send_query(pack_query(FUNC_BOX, 50 * UNIT, 50 * UNIT, 50 * UNIT,
                          150 * UNIT, 150 * UNIT, 150 * UNIT, 0));
    send_query(pack_query(FUNC_BOX, 150 * UNIT, 0, 0, 250 * UNIT, UNIT, UNIT, 0));
    send_query(pack_query(FUNC_BOX, 50 * UNIT, 50 * UNIT, 50 * UNIT,
                          -50 * UNIT, -50 * UNIT, -50 * UNIT, 0));
    send_query(pack_query(FUNC_BOX, -8388608, -8388608, -8388608,
                          8388607, 8388607, 8388607, 0));
    send_query(pack_query(FUNC_NONE, 0, 0, 0, 0, 0, 0, 0));
    settle();
  endtask

  task automatic run_phase(input int span);
    repeat (PHASE_WORDS) send_query(random_query(span));
    settle();
  endtask

  task automatic test_random_stream();
    load_cube(100 * UNIT);
    run_phase(150 * UNIT);
    no_gaps = 1'b1;
    run_phase(150 * UNIT);
    no_gaps = 1'b0;
    load_cube(UNIT);
    run_phase(2 * UNIT);
    load_skewed_planes(1'b0);
    run_phase(1 << 16);
    load_skewed_planes(1'b1);
    run_phase(1 << 20);
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    func_i = FUNC_POINT;
    x_low_i = '0;
    y_low_i = '0;
    z_low_i = '0;
    x_high_i = '0;
    y_high_i = '0;
    z_high_i = '0;
    radius_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = PLANE_RIGHT;
    cfg_data_i = '0;
    foreach (plane_set[k]) plane_set[k] = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_zero_planes();
    test_plane_registers();
    test_directed_cube();
    test_random_stream();
    settle();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
